/* rtl/tdf_pkg.sv */
`default_nettype none

package tdf_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned FIELD_BITS     = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH,
    ST_LAST
  } tdf_state_e;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdf_div_stat_t;

endpackage

`default_nettype wire

/* rtl/tdf_divider.sv */
`default_nettype none

module tdf_divider import tdf_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned DIV_BITS   = VALUE_BITS / 2 + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [DIV_BITS-1:0]   divisor_i,
  output tdf_div_stat_t              stat_o,
  output logic      [VALUE_BITS-1:0] quotient_o
);

  localparam int unsigned CntBits = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [DIV_BITS:0]     rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIV_BITS-1:0]   dsr_q, dsr_d;
  logic [DIV_BITS:0]     trial;
  logic                  ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    trial  = {rem_q[DIV_BITS-1:0], quo_q[VALUE_BITS-1]};
    ge     = (trial >= {1'b0, dsr_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(VALUE_BITS);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (trial - {1'b0, dsr_q}) : trial;
      quo_d = {quo_q[VALUE_BITS-2:0], ge};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);
  assign quotient_o      = quo_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < {1'b0, dsr_q}))
    else $error("remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a running division");

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> busy_q || done_q)
    else $error("division stopped without done");

endmodule

`default_nettype wire

/* rtl/trial_division_factorizer_core.sv */
// Channel  | Ports                                        | Direction | Beat
// ---------+----------------------------------------------+-----------+-------------------------
// command  | start_i, busy_o, value_i                     | in        | start_i && !busy_o
// result   | result_valid_o, prime_factor_o, is_last_o,   | out       | result_valid_o, 1 cycle
//          | no_factors_o                                 |           |
//
// A value of zero or one gives its empty result in the cycle after the command beat.
// Otherwise the factors of two are stripped first, and then each trial division runs in the
// shared divider; a prime near 2^32 needs about 32768 divisions before it is reported.
// Each factor leaves one beat after it is found, so that the final one can be marked;
// busy_o falls with the final result beat. Reset is asynchronous, active low, to idle.
// The receiver cannot stall: every result beat is taken in its cycle.
`default_nettype none

module trial_division_factorizer_core import tdf_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [FIELD_BITS-1:0] value_i,
  output logic                       result_valid_o,
  output logic      [FIELD_BITS-1:0] prime_factor_o,
  output logic                       is_last_o,
  output logic                       no_factors_o
);

  localparam int unsigned DivBits = VALUE_BITS / 2 + 2;

  tdf_state_e            state_q, state_d;
  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [DivBits-1:0]    d_q, d_d;
  logic                  inner_q, inner_d;
  logic                  pend_v_q, pend_v_d;
  logic [VALUE_BITS-1:0] pend_q, pend_d;
  logic                  out_v_q, out_v_d;
  logic [FIELD_BITS-1:0] out_f_q, out_f_d;
  logic                  out_l_q, out_l_d;
  logic                  out_e_q, out_e_d;
  logic [VALUE_BITS-1:0] n_in;
  logic                  div_start;
  tdf_div_stat_t         div_stat;
  logic [VALUE_BITS-1:0] div_quo;
  logic                  emit;
  logic [VALUE_BITS-1:0] emit_val;

  tdf_divider #(
    .VALUE_BITS(VALUE_BITS),
    .DIV_BITS  (DivBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    d_d       = d_q;
    inner_d   = inner_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    out_v_d   = 1'b0;
    out_f_d   = out_f_q;
    out_l_d   = 1'b0;
    out_e_d   = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    emit_val  = '0;
    n_in      = VALUE_BITS'(value_i);

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (n_in <= VALUE_BITS'(1)) begin
            out_v_d = 1'b1;
            out_f_d = '0;
            out_l_d = 1'b1;
            out_e_d = 1'b1;
          end else begin
            n_d      = n_in;
            d_d      = DivBits'(3);
            inner_d  = 1'b0;
            pend_v_d = 1'b0;
            state_d  = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (!n_q[0]) begin
          emit     = 1'b1;
          emit_val = VALUE_BITS'(2);
          n_d      = n_q >> 1;
        end else begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (!inner_q && (VALUE_BITS'(d_q) > div_quo)) begin
            state_d = ST_FINISH;
          end else if (div_stat.rem_zero) begin
            emit     = 1'b1;
            emit_val = VALUE_BITS'(d_q);
            n_d      = div_quo;
            inner_d  = 1'b1;
            state_d  = ST_DIV_START;
          end else begin
            d_d     = d_q + DivBits'(2);
            inner_d = 1'b0;
            state_d = ST_DIV_START;
          end
        end
      end
      ST_FINISH: begin
        if (n_q > VALUE_BITS'(1)) begin
          emit     = 1'b1;
          emit_val = n_q;
        end
        state_d = ST_LAST;
      end
      ST_LAST: begin
        out_v_d  = 1'b1;
        out_f_d  = FIELD_BITS'(pend_q);
        out_l_d  = 1'b1;
        pend_v_d = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_v_d  = pend_v_q;
      out_f_d  = FIELD_BITS'(pend_q);
      pend_v_d = 1'b1;
      pend_d   = emit_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      inner_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      out_l_q  <= 1'b0;
      out_e_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      inner_q  <= inner_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      out_l_q  <= out_l_d;
      out_e_q  <= out_e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    pend_q  <= pend_d;
    out_f_q <= out_f_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = out_v_q;
  assign prime_factor_o = out_f_q;
  assign is_last_o      = out_l_q;
  assign no_factors_o   = out_e_q;

  a_fall_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o && is_last_o && !no_factors_o)
    else $error("run ended without its final result");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && no_factors_o |-> is_last_o && (prime_factor_o == '0) && !busy_o)
    else $error("malformed empty result");

  a_last_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAST) |-> pend_v_q)
    else $error("final beat without a held factor");

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == ST_DIV_WAIT) && !div_stat.done)
    else $error("divider started out of sequence");

endmodule

`default_nettype wire

/* sim/trial_division_factorizer_core_test.sv */
`default_nettype none

module trial_division_factorizer_core_test import tdf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 400000;
  localparam int unsigned TRY_BOUND   = 600;
  localparam int unsigned N_RANDOM    = 80;
  localparam int unsigned N_DIRECTED  = 21;
  localparam logic [63:0] VALUE_MASK  = {64{1'b1}} >> (64 - VALUE_BITS_DEF);

  typedef struct packed {
    logic [FIELD_BITS-1:0] prime_factor;
    logic                  is_last;
    logic                  no_factors;
  } factor_beat_t;

  typedef struct {
    logic [FIELD_BITS-1:0] value;
    bit                    typed;
    factor_beat_t          beat;
  } directed_row_t;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start_i = 1'b0;
  logic [FIELD_BITS-1:0] value_i = '0;
  logic                  busy_o;
  logic                  result_valid_o;
  logic [FIELD_BITS-1:0] prime_factor_o;
  logic                  is_last_o;
  logic                  no_factors_o;

  factor_beat_t predicted[$];
  factor_beat_t expected_factors[$];
  int unsigned  mismatches   = 0;
  int unsigned  quiet_cycles = 0;
  bit           burst        = 1'b0;
  bit           timed_out    = 1'b0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{32'd0,          1'b1, '{32'd0,     1'b1, 1'b1}},
    '{32'd1,          1'b1, '{32'd0,     1'b1, 1'b1}},
    '{32'd2,          1'b1, '{32'd2,     1'b1, 1'b0}},
    '{32'd3,          1'b1, '{32'd3,     1'b1, 1'b0}},
    '{32'd65537,      1'b1, '{32'd65537, 1'b1, 1'b0}},
    '{32'hFFFFFFFF,   1'b0, '0},
    '{32'h80000000,   1'b0, '0},
    '{32'd4,          1'b0, '0},
    '{32'd6,          1'b0, '0},
    '{32'd9,          1'b0, '0},
    '{32'd12,         1'b0, '0},
    '{32'd25,         1'b0, '0},
    '{32'd30,         1'b0, '0},
    '{32'd49,         1'b0, '0},
    '{32'd121,        1'b0, '0},
    '{32'd1048573,    1'b0, '0},
    '{32'd3486784401, 1'b0, '0},
    '{32'h55555555,   1'b0, '0},
    '{32'hAAAAAAAA,   1'b0, '0},
    '{32'hC0000000,   1'b0, '0},
    '{32'h0000FFFF,   1'b0, '0}
  };

  trial_division_factorizer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .prime_factor_o (prime_factor_o),
    .is_last_o      (is_last_o),
    .no_factors_o   (no_factors_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void append_beat(ref factor_beat_t q[$], input factor_beat_t b);
    q.insert(q.size(), b);
  endfunction

  // Fills the scratch queue with the factors of one value and returns the number of
  // odd trial divisors tried, which is what makes a run long.
  function automatic int unsigned factorize(input logic [FIELD_BITS-1:0] value);
    logic [63:0]  cofactor;
    logic [63:0]  divisor;
    int unsigned  tries;
    cofactor = 64'(value) & VALUE_MASK;
    tries = 0;
    predicted.delete();
    if (cofactor <= 64'd1) begin
      append_beat(predicted, factor_beat_t'{'0, 1'b1, 1'b1});
      return 0;
    end
    while (cofactor[0] == 1'b0) begin
      append_beat(predicted, factor_beat_t'{FIELD_BITS'(2), 1'b0, 1'b0});
      cofactor = cofactor >> 1;
    end
    divisor = 64'd3;
    while (divisor <= cofactor / divisor) begin
      tries++;
      while (cofactor % divisor == 64'd0) begin
        append_beat(predicted, factor_beat_t'{FIELD_BITS'(divisor), 1'b0, 1'b0});
        cofactor = cofactor / divisor;
      end
      divisor = divisor + 64'd2;
    end
    if (cofactor > 64'd1) begin
      append_beat(predicted, factor_beat_t'{FIELD_BITS'(cofactor), 1'b0, 1'b0});
    end
    predicted[predicted.size() - 1].is_last = 1'b1;
    return tries;
  endfunction

  function automatic logic [FIELD_BITS-1:0] draw_value();
    logic [63:0] product;
    logic [63:0] multiplier;
    logic [FIELD_BITS-1:0] value;
    case ($urandom_range(0, 9))
      0, 1, 2: value = FIELD_BITS'($urandom_range(0, 4095));
      3, 4: value = FIELD_BITS'($urandom_range(1, 255)) << $urandom_range(0, 24);
      5, 6: begin
        product = 64'd1;
        repeat ($urandom_range(1, 12)) begin
          multiplier = 64'($urandom_range(2, 47));
          if (product * multiplier <= 64'hFFFFFFFF) product = product * multiplier;
        end
        value = FIELD_BITS'(product);
      end
      default: begin
        value = FIELD_BITS'($urandom);
        while (factorize(value) > TRY_BOUND) value = FIELD_BITS'($urandom);
      end
    endcase
    return value;
  endfunction

  task automatic send_value(input logic [FIELD_BITS-1:0] value, input bit typed,
                            input factor_beat_t typed_beat);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (typed) begin
      predicted.delete();
      append_beat(predicted, typed_beat);
    end else begin
      void'(factorize(value));
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    foreach (predicted[i]) append_beat(expected_factors, predicted[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    factor_beat_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_factors.size() == 0) begin
        $error("unexpected result beat: prime_factor %0d", prime_factor_o);
        mismatches++;
      end else begin
        want = expected_factors.pop_front();
        if (prime_factor_o !== want.prime_factor) begin
          $error("prime_factor: expected %0d, got %0d", want.prime_factor, prime_factor_o);
          mismatches++;
        end
        if (is_last_o !== want.is_last) begin
          $error("is_last: expected %0d, got %0d", want.is_last, is_last_o);
          mismatches++;
        end
        if (no_factors_o !== want.no_factors) begin
          $error("no_factors: expected %0d, got %0d", want.no_factors, no_factors_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        foreach (directed_rows[i]) begin
          send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].beat);
        end
        for (int unsigned i = 0; i < N_RANDOM; i++) begin
          if (i % 8 == 0) burst = ($urandom_range(0, 3) == 0);
          send_value(draw_value(), 1'b0, '0);
        end
        start_i <= 1'b0;
        while (expected_factors.size() != 0) @(posedge clk_i);
        repeat (64) @(posedge clk_i);
      end
      begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && mismatches == 0 && expected_factors.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
